### sv/mac_vendor_prefix_lookup_assert.svh
// ----------------------------------------------------------------------------
// mac vendor prefix lookup assertion macros
// shared concurrent check forms, clocked on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef MAC_VENDOR_PREFIX_LOOKUP_ASSERT_SVH
`define MAC_VENDOR_PREFIX_LOOKUP_ASSERT_SVH

// same-cycle implication
`define MVPL_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mvpl check failed");

// next-cycle implication
`define MVPL_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mvpl next-cycle check failed");

`endif

### sv/mvpl_pkg.sv
// ----------------------------------------------------------------------------
// mvpl_pkg
// types, constants and key helpers shared by the mac prefix lookup block
// ----------------------------------------------------------------------------
`default_nettype none

package mvpl_pkg;

	// table geometry
	localparam int TABLE_ENTRIES  = 256;
	localparam int IDX_W          = $clog2(TABLE_ENTRIES);
	localparam int CNT_W          = $clog2(TABLE_ENTRIES + 1);
	localparam int VENDOR_ID_BITS = 16;
	localparam int VALUE_W        = 36;
	localparam int KEY_W          = VALUE_W + 2;
	localparam int MAC_W          = 48;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// size classes
	localparam logic [1:0] SIZE_24 = 2'd0;
	localparam logic [1:0] SIZE_28 = 2'd1;
	localparam logic [1:0] SIZE_36 = 2'd2;
	localparam logic [1:0] SIZE_NONE = 2'd3;

	// insert status codes
	localparam logic [1:0] STAT_STORED = 2'd0;
	localparam logic [1:0] STAT_DUP    = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	// search keys broadcast to every cell for one request
	typedef struct packed {
		logic [KEY_W-1:0] k36;
		logic [KEY_W-1:0] k28;
		logic [KEY_W-1:0] k24;
	} keys_t;

	// token handed from cell to cell, accumulating hits per size class
	typedef struct packed {
		logic                      valid;
		logic                      hit36;
		logic                      hit28;
		logic                      hit24;
		logic [VENDOR_ID_BITS-1:0] vid36;
		logic [VENDOR_ID_BITS-1:0] vid28;
		logic [VENDOR_ID_BITS-1:0] vid24;
	} tok_t;

	// entry write from control to the row of cells
	typedef struct packed {
		logic                      en;
		logic [IDX_W-1:0]          idx;
		logic [KEY_W-1:0]          key;
		logic [VENDOR_ID_BITS-1:0] vendor;
	} wr_t;

	// mask the prefix to its size class and tag it with the class
	function automatic logic [KEY_W-1:0] make_key(input logic [VALUE_W-1:0] prefix,
	                                              input logic [1:0] size);
		logic [VALUE_W-1:0] value;
		case (size)
			SIZE_24: value = {12'd0, prefix[23:0]};
			SIZE_28: value = {8'd0, prefix[27:0]};
			default: value = prefix;
		endcase
		return {size, value};
	endfunction

endpackage

`default_nettype wire

### sv/mvpl_cell.sv
// ----------------------------------------------------------------------------
// mvpl_cell
// one table entry: stores key and vendor, compares against the search keys
// when the token passes and hands the token on to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module mvpl_cell (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mvpl_pkg::keys_t                     keys,
	input  wire mvpl_pkg::tok_t                      tok_in,
	input  wire logic                                wr_sel,
	input  wire logic [mvpl_pkg::KEY_W-1:0]          wr_key,
	input  wire logic [mvpl_pkg::VENDOR_ID_BITS-1:0] wr_vendor,
	output mvpl_pkg::tok_t                           tok_out
);

	logic                                valid_q;
	logic [mvpl_pkg::KEY_W-1:0]          key_q;
	logic [mvpl_pkg::VENDOR_ID_BITS-1:0] vendor_q;
	mvpl_pkg::tok_t                      tok_q;
	mvpl_pkg::tok_t                      tok_nxt;
	logic                                m36;
	logic                                m28;
	logic                                m24;

	// entry storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_sel) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			key_q    <= wr_key;
			vendor_q <= wr_vendor;
		end
	end

	// compare against all three keys, keep the first hit of each class
	always_comb begin
		m36 = valid_q && (key_q == keys.k36);
		m28 = valid_q && (key_q == keys.k28);
		m24 = valid_q && (key_q == keys.k24);
		tok_nxt       = tok_in;
		tok_nxt.hit36 = tok_in.hit36 | m36;
		tok_nxt.hit28 = tok_in.hit28 | m28;
		tok_nxt.hit24 = tok_in.hit24 | m24;
		if (!tok_in.hit36 && m36) begin
			tok_nxt.vid36 = vendor_q;
		end
		if (!tok_in.hit28 && m28) begin
			tok_nxt.vid28 = vendor_q;
		end
		if (!tok_in.hit24 && m24) begin
			tok_nxt.vid24 = vendor_q;
		end
	end

	// hand-off register to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

### sv/mvpl_ctrl.sv
// ----------------------------------------------------------------------------
// mvpl_ctrl
// request capture, sweep sequencing, fill count and result formation
// ----------------------------------------------------------------------------
`default_nettype none

`include "mac_vendor_prefix_lookup_assert.svh"

module mvpl_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                operation,
	input  wire logic [mvpl_pkg::MAC_W-1:0]          mac_address,
	input  wire logic [mvpl_pkg::VALUE_W-1:0]        entry_prefix,
	input  wire logic [1:0]                          entry_size,
	input  wire logic [mvpl_pkg::VENDOR_ID_BITS-1:0] entry_vendor,
	output mvpl_pkg::keys_t                          keys,
	output mvpl_pkg::tok_t                           head,
	input  wire mvpl_pkg::tok_t                      tail,
	output mvpl_pkg::wr_t                            wr,
	output logic                                     done,
	output logic                                     found,
	output logic [mvpl_pkg::VENDOR_ID_BITS-1:0]      vendor_id,
	output logic [1:0]                               match_size,
	output logic [1:0]                               insert_status
);

	mvpl_pkg::state_t                    state_q;
	mvpl_pkg::state_t                    state_nxt;
	logic                                accept;
	logic                                launch_q;
	logic                                op_q;
	logic                                ins_ok_q;
	mvpl_pkg::keys_t                     keys_q;
	mvpl_pkg::keys_t                     keys_nxt;
	logic [mvpl_pkg::VENDOR_ID_BITS-1:0] vend_q;
	logic [mvpl_pkg::CNT_W-1:0]          count_q;
	logic                                full;
	logic                                done_q;
	logic                                found_q;
	logic [mvpl_pkg::VENDOR_ID_BITS-1:0] vid_q;
	logic [1:0]                          size_q;
	logic [1:0]                          stat_q;
	logic                                found_nxt;
	logic [mvpl_pkg::VENDOR_ID_BITS-1:0] vid_nxt;
	logic [1:0]                          size_nxt;
	logic [1:0]                          stat_nxt;

	assign accept = start && !busy;
	assign full   = (count_q >= mvpl_pkg::CNT_W'(mvpl_pkg::TABLE_ENTRIES));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mvpl_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = mvpl_pkg::ST_SWEEP;
				end
			end
			mvpl_pkg::ST_SWEEP: begin
				if (tail.valid) begin
					state_nxt = mvpl_pkg::ST_IDLE;
				end
			end
			default: state_nxt = mvpl_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		case (state_q)
			mvpl_pkg::ST_IDLE:  busy = 1'b0;
			mvpl_pkg::ST_SWEEP: busy = 1'b1;
			default:            busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mvpl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// search keys: lookup tries three prefix lengths, insert checks its own key
	always_comb begin
		if (operation == mvpl_pkg::OP_LOOKUP) begin
			keys_nxt.k36 = {mvpl_pkg::SIZE_36, mac_address[47:12]};
			keys_nxt.k28 = {mvpl_pkg::SIZE_28, 8'd0, mac_address[47:20]};
			keys_nxt.k24 = {mvpl_pkg::SIZE_24, 12'd0, mac_address[47:24]};
		end else begin
			keys_nxt.k36 = mvpl_pkg::make_key(entry_prefix, entry_size);
			keys_nxt.k28 = keys_nxt.k36;
			keys_nxt.k24 = keys_nxt.k36;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			ins_ok_q <= (entry_size != mvpl_pkg::SIZE_NONE);
			keys_q   <= keys_nxt;
			vend_q   <= entry_vendor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= 1'b0;
		end else begin
			launch_q <= accept;
		end
	end

	assign keys = keys_q;

	// token entering the first cell
	always_comb begin
		head       = '0;
		head.valid = launch_q;
	end

	// entry write when an insert of a valid size class finds no duplicate and room is left
	always_comb begin
		wr.en     = tail.valid && (op_q == mvpl_pkg::OP_INSERT) && ins_ok_q
		            && !tail.hit36 && !full;
		wr.idx    = count_q[mvpl_pkg::IDX_W-1:0];
		wr.key    = keys_q.k36;
		wr.vendor = vend_q;
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr.en) begin
			count_q <= count_q + 1'b1;
		end
	end

	// result formation at the end of the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid;
		end
	end

	// longest hit wins for a lookup, duplicate before full for an insert
	always_comb begin
		found_nxt = 1'b0;
		vid_nxt   = '0;
		size_nxt  = mvpl_pkg::SIZE_24;
		stat_nxt  = mvpl_pkg::STAT_STORED;
		if (op_q == mvpl_pkg::OP_LOOKUP) begin
			if (tail.hit36) begin
				found_nxt = 1'b1;
				vid_nxt   = tail.vid36;
				size_nxt  = mvpl_pkg::SIZE_36;
			end else if (tail.hit28) begin
				found_nxt = 1'b1;
				vid_nxt   = tail.vid28;
				size_nxt  = mvpl_pkg::SIZE_28;
			end else if (tail.hit24) begin
				found_nxt = 1'b1;
				vid_nxt   = tail.vid24;
				size_nxt  = mvpl_pkg::SIZE_24;
			end
		end else if (ins_ok_q) begin
			if (tail.hit36) begin
				stat_nxt = mvpl_pkg::STAT_DUP;
			end else if (full) begin
				stat_nxt = mvpl_pkg::STAT_FULL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			found_q <= found_nxt;
			vid_q   <= vid_nxt;
			size_q  <= size_nxt;
			stat_q  <= stat_nxt;
		end
	end

	assign done          = done_q;
	assign found         = found_q;
	assign vendor_id     = vid_q;
	assign match_size    = size_q;
	assign insert_status = stat_q;

	// checks
	`MVPL_CHECK(a_done_idle, done_q, state_q == mvpl_pkg::ST_IDLE)
	`MVPL_CHECK(a_tail_in_sweep, tail.valid, state_q == mvpl_pkg::ST_SWEEP)
	`MVPL_CHECK(a_count_bound, 1'b1,
		count_q <= mvpl_pkg::CNT_W'(mvpl_pkg::TABLE_ENTRIES))
	`MVPL_CHECK_NEXT(a_accept_launch, accept, launch_q && busy)
	`MVPL_CHECK_NEXT(a_write_counts, wr.en, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

### sv/mac_vendor_prefix_lookup.sv
// ----------------------------------------------------------------------------
// mac_vendor_prefix_lookup
// mac vendor prefix table with longest-prefix lookup over a row of cells
// ----------------------------------------------------------------------------
//
// channel   direction  handshake      payload
// request   in         start / busy   operation, mac_address, entry_prefix,
//                                     entry_size, entry_vendor
// result    out        done strobe    found, vendor_id, match_size,
//                                     insert_status
//
// each request lasts until the search token has walked the row of cells, one cell
// per cycle.
// a request is taken when start is high and busy is low; busy rises the next
// cycle and falls with the done strobe, so a new request may be taken in the
// cycle that the result is shown.
// done is high for one cycle with the result; the receiver cannot stall.
// arst_n clears all entry valid bits and the fill count at once; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_vendor_prefix_lookup (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                operation,
	input  wire logic [mvpl_pkg::MAC_W-1:0]          mac_address,
	input  wire logic [mvpl_pkg::VALUE_W-1:0]        entry_prefix,
	input  wire logic [1:0]                          entry_size,
	input  wire logic [mvpl_pkg::VENDOR_ID_BITS-1:0] entry_vendor,
	output logic                                     done,
	output logic                                     found,
	output logic [mvpl_pkg::VENDOR_ID_BITS-1:0]      vendor_id,
	output logic [1:0]                               match_size,
	output logic [1:0]                               insert_status
);

	mvpl_pkg::keys_t keys;
	mvpl_pkg::wr_t   wr;
	mvpl_pkg::tok_t  tok [mvpl_pkg::TABLE_ENTRIES+1];

	// sequencing and result
	mvpl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.mac_address   (mac_address),
		.entry_prefix  (entry_prefix),
		.entry_size    (entry_size),
		.entry_vendor  (entry_vendor),
		.keys          (keys),
		.head          (tok[0]),
		.tail          (tok[mvpl_pkg::TABLE_ENTRIES]),
		.wr            (wr),
		.done          (done),
		.found         (found),
		.vendor_id     (vendor_id),
		.match_size    (match_size),
		.insert_status (insert_status)
	);

	// row of entry cells
	for (genvar i = 0; i < mvpl_pkg::TABLE_ENTRIES; i++) begin : g_cell
		logic sel;
		assign sel = wr.en && (wr.idx == mvpl_pkg::IDX_W'(i));

		mvpl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.keys      (keys),
			.tok_in    (tok[i]),
			.wr_sel    (sel),
			.wr_key    (wr.key),
			.wr_vendor (wr.vendor),
			.tok_out   (tok[i+1])
		);
	end

endmodule

`default_nettype wire
